// ===== design/lhist_pkg.sv =====
// shared types, constants and helper functions for the log2 latency histogram
// no dependencies; imported by log2_latency_histogram_top and lhist_div

package lhist_pkg;

    localparam int NUM_BUCKETS_DEF = 48;

    localparam logic [1:0] FUNC_RECORD = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam int CNT_W     = 32;
    localparam int VALUE_W   = 33;
    localparam int PERMIL_W  = 10;
    localparam int DIVISOR   = 1000;
    localparam int PROD_W    = CNT_W + PERMIL_W;
    localparam int QUOT_W    = 33;
    localparam int BKT_W     = 6;

    typedef struct packed {
        logic [1:0]          func;
        logic signed [63:0]  sample;
        logic [PERMIL_W-1:0] percentile_permille;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] percentile_value;
        logic [CNT_W-1:0]   sample_count;
        logic [CNT_W-1:0]   max_value;
    } rsp_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // negative goes to zero, anything above 32 bits saturates
    function automatic logic [CNT_W-1:0] clamp_sample(input logic [63:0] raw);
        logic [CNT_W-1:0] v;
        if (raw[63])
        begin
            v = '0;
        end
        else if (raw[62:32] != '0)
        begin
            v = '1;
        end
        else
        begin
            v = raw[31:0];
        end
        return v;
    endfunction

    // position of the highest set bit plus one, zero for a zero value
    function automatic logic [BKT_W-1:0] bucket_of(input logic [CNT_W-1:0] v);
        logic [BKT_W-1:0] b;
        b = '0;
        for (int k = 0; k < CNT_W; k++)
        begin
            if (v[k])
            begin
                b = BKT_W'(k + 1);
            end
        end
        return b;
    endfunction

endpackage

// ===== design/log2_latency_histogram_top.sv =====
// log2 latency histogram: bucket counts in one ram, record/query/clear sequencer
// depends on lhist_pkg, lhist_ram, lhist_div
// record: accept, bucket read, write back; clear and unused codes: accept only
// query: accept, the divider's two-pass reciprocal multiply, the one-bucket-per-cycle
//   ram scan up to the last bucket, then the result
// one item at a time; the result register lets the next item in while a result waits
// reset clears counts at once through per-bucket valid bits, no clearing pass

module log2_latency_histogram_top #(
    parameter int NUM_BUCKETS = lhist_pkg::NUM_BUCKETS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  lhist_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output lhist_pkg::rsp_t rsp
);

    import lhist_pkg::*;

    localparam int AW  = $clog2(NUM_BUCKETS);
    localparam int SUM_W = CNT_W + $clog2(NUM_BUCKETS);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_REC_RD = 6'b000010,
        S_REC_WR = 6'b000100,
        S_DIV    = 6'b001000,
        S_SCAN   = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [NUM_BUCKETS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]       total_reg, total_next;
    logic [CNT_W-1:0]       max_reg, max_next;
    logic                   out_valid_reg, out_valid_next;
    logic [AW-1:0]          issue_reg, issue_next;
    logic                   dvalid_reg, dvalid_next;

    logic [CNT_W-1:0]       val_reg, val_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic [AW-1:0]          didx_reg, didx_next;
    logic [QUOT_W-1:0]      target_reg, target_next;
    logic [SUM_W-1:0]       cum_reg, cum_next;
    logic [VALUE_W-1:0]     res_reg, res_next;
    rsp_t                   out_reg, out_next;

    logic                   accept;
    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [CNT_W-1:0]       ram_wdata, ram_rdata;
    logic                   div_start;
    logic [PROD_W-1:0]      div_dividend;
    div_stat_t              div_stat;
    logic [QUOT_W-1:0]      div_quot;
    logic [BKT_W-1:0]       bkt;
    logic [AW-1:0]          bkt_addr;
    logic [CNT_W-1:0]       entry;
    logic [SUM_W-1:0]       cum_sum;
    logic [VALUE_W-1:0]     bkt_edge;
    logic [CNT_W-1:0]       clamped;

    assign accept    = req_valid && (state_reg == S_IDLE);
    assign req_stall = (state_reg != S_IDLE);

    assign clamped  = clamp_sample(req.sample);
    assign bkt      = bucket_of(val_reg);
    assign bkt_addr = (int'(bkt) > NUM_BUCKETS - 1) ? AW'(NUM_BUCKETS - 1) : AW'(bkt);

    assign div_dividend = PROD_W'(total_reg) * PROD_W'(req.percentile_permille);

    // entries never written since reset or clear read as zero
    always_comb
    begin
        entry = '0;
        if (state_reg == S_REC_WR)
        begin
            entry = valid_reg[addr_reg] ? ram_rdata : '0;
        end
        else
        begin
            entry = valid_reg[didx_reg] ? ram_rdata : '0;
        end
    end

    assign cum_sum = cum_reg + SUM_W'(entry);

    always_comb
    begin
        if (didx_reg == '0)
        begin
            bkt_edge = '0;
        end
        else if (int'(didx_reg) > CNT_W)
        begin
            bkt_edge = '1;
        end
        else
        begin
            bkt_edge = VALUE_W'(1) << didx_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        total_next     = total_reg;
        max_next       = max_reg;
        out_valid_next = out_valid_reg;
        issue_next     = issue_reg;
        dvalid_next    = 1'b0;
        val_next       = val_reg;
        addr_next      = addr_reg;
        didx_next      = didx_reg;
        target_next    = target_reg;
        cum_next       = cum_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = entry + CNT_W'(1);
        ram_raddr      = issue_reg;
        div_start      = 1'b0;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.func)
                        FUNC_RECORD:
                        begin
                            val_next   = clamped;
                            total_next = total_reg + CNT_W'(1);
                            if (clamped > max_reg)
                            begin
                                max_next = clamped;
                            end
                            state_next = S_REC_RD;
                        end
                        FUNC_QUERY:
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                        FUNC_CLEAR:
                        begin
                            valid_next = '0;
                            total_next = '0;
                            max_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_REC_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = bkt_addr;
                addr_next  = bkt_addr;
                state_next = S_REC_WR;
            end
            S_REC_WR:
            begin
                ram_we              = 1'b1;
                valid_next[addr_reg] = 1'b1;
                state_next          = S_IDLE;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    target_next = div_quot;
                    cum_next    = '0;
                    issue_next  = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // reads run one bucket ahead of the accumulate
                ram_re      = 1'b1;
                issue_next  = issue_reg + AW'(1);
                dvalid_next = 1'b1;
                didx_next   = issue_reg;
                if (dvalid_reg)
                begin
                    cum_next = cum_sum;
                    if (cum_sum >= SUM_W'(target_reg))
                    begin
                        res_next    = bkt_edge;
                        dvalid_next = 1'b0;
                        state_next  = S_RESULT;
                    end
                    else if (didx_reg == AW'(NUM_BUCKETS - 1))
                    begin
                        res_next    = VALUE_W'(max_reg);
                        dvalid_next = 1'b0;
                        state_next  = S_RESULT;
                    end
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next.percentile_value = res_reg;
                    out_next.sample_count     = total_reg;
                    out_next.max_value        = max_reg;
                    out_valid_next            = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            total_reg     <= '0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
            issue_reg     <= '0;
            dvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            total_reg     <= total_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
            issue_reg     <= issue_next;
            dvalid_reg    <= dvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        addr_reg   <= addr_next;
        didx_reg   <= didx_next;
        target_reg <= target_next;
        cum_reg    <= cum_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    lhist_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lhist_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ===== design/lhist_ram.sv =====
// generic single-write, single-read memory with registered read data
// no dependencies

module lhist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/lhist_div.sv =====
// divide by the per-mille constant: drop three bits, then multiply by a scaled
// reciprocal of 125 in two 20-bit halves, low half then high half; depends on lhist_pkg

module lhist_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lhist_pkg::PROD_W-1:0] dividend,
    output lhist_pkg::div_stat_t         stat,
    output logic [lhist_pkg::QUOT_W-1:0] quotient
);

    import lhist_pkg::*;

    // 1000 = 8 * 125, and floor(y / 125) = (y * ceil(2^46 / 125)) >> 46 for y < 2^39
    localparam int Y_W         = PROD_W - 3;
    localparam int HALF_W      = 20;
    localparam int PART_W      = Y_W + HALF_W;
    localparam int ACC_W       = Y_W + 2 * HALF_W;
    localparam int RECIP_SHIFT = 46;
    // ceil(2^46 / 125) = 40'h83_126E_978E
    localparam logic [HALF_W-1:0] RECIP_HI = 20'h83126;
    localparam logic [HALF_W-1:0] RECIP_LO = 20'hE978E;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              high_reg, high_next;
    logic [Y_W-1:0]    y_reg, y_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [HALF_W-1:0] recip_half;
    logic [PART_W-1:0] partial;

    assign recip_half = high_reg ? RECIP_HI : RECIP_LO;
    assign partial    = PART_W'(y_reg) * PART_W'(recip_half);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        high_next = high_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            high_next = 1'b0;
            y_next    = dividend[PROD_W-1:PROD_W-Y_W];
        end
        else if (busy_reg)
        begin
            if (!high_reg)
            begin
                acc_next  = ACC_W'(partial);
                high_next = 1'b1;
            end
            else
            begin
                acc_next  = acc_reg + {partial, {HALF_W{1'b0}}};
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            high_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            high_reg <= high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg   <= y_next;
        acc_reg <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = acc_reg[RECIP_SHIFT +: QUOT_W];

endmodule
